// ----- design/cfr_pkg.sv -----
// Shared types, constants and codes for the CAN frame reassembler.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int LANES        = 8;
  localparam int LANE_W       = 3;
  localparam int ROWS         = BUFFER_BYTES / LANES;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int LEN_W        = 7;
  localparam int SEGNUM_W     = 7;
  localparam int STATION_W    = 8;
  localparam int DLC_W        = 4;

  localparam logic [DLC_W-1:0] MAX_DLC = 4'd8;

  // Segment position codes carried in ext_id[20:19]
  localparam logic [1:0] SEG_NONE   = 2'd0;
  localparam logic [1:0] SEG_FIRST  = 2'd1;
  localparam logic [1:0] SEG_MIDDLE = 2'd2;
  localparam logic [1:0] SEG_FINAL  = 2'd3;

  typedef struct packed {
    logic [28:0] ext_id;
    logic [3:0]  dlc;
    logic [63:0] frame_data;
  } cfr_in_t;

  typedef struct packed {
    logic [3:0]       func_code;
    logic [7:0]       source_station;
    logic [LEN_W-1:0] message_length;
    logic [2:0]       chunk_index;
    logic [63:0]      chunk_bytes;
    logic             last_chunk;
  } cfr_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;       // capture input transaction
    logic store;       // write frame bytes into buffer
    logic append;      // store at assembled offset instead of offset 0
    logic seg_open;    // first frame: open reassembly
    logic seg_advance; // middle frame accepted
    logic seg_close;   // final frame accepted
    logic emit;        // load message length, reset chunk counter
    logic read;        // read one buffer row
    logic next_chunk;  // advance to next chunk
  } cfr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic       dst_match;
    logic [1:0] segpos;
    logic       fits;
    logic       last_chunk;
  } cfr_status_t;

endpackage

// ----- design/cfr_ctrl.sv -----
// Controller state machine for the CAN frame reassembler.
`timescale 1ns / 1ps

module cfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cfr_pkg::cfr_status_t status,
  output cfr_pkg::cfr_cmd_t    cmd
);
  import cfr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PROC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        state_nxt = S_IDLE;
        if (status.dst_match) begin
          unique case (status.segpos)
            SEG_NONE: begin
              cmd.store = 1'b1;
              cmd.emit  = 1'b1;
              state_nxt = S_READ;
            end
            SEG_FIRST: begin
              cmd.store    = 1'b1;
              cmd.seg_open = 1'b1;
            end
            SEG_MIDDLE: begin
              if (status.fits) begin
                cmd.store       = 1'b1;
                cmd.append      = 1'b1;
                cmd.seg_advance = 1'b1;
              end
            end
            SEG_FINAL: begin
              if (status.fits) begin
                cmd.store     = 1'b1;
                cmd.append    = 1'b1;
                cmd.seg_close = 1'b1;
                cmd.emit      = 1'b1;
                state_nxt     = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (status.last_chunk) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_chunk = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/cfr_datapath.sv -----
// Datapath: frame decode, segment tracking, banked message buffer, chunk output.
`timescale 1ns / 1ps

module cfr_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfr_pkg::cfr_in_t     in_data,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  cfr_pkg::cfr_cmd_t    cmd,
  output cfr_pkg::cfr_status_t status,
  output cfr_pkg::cfr_out_t    out_data
);
  import cfr_pkg::*;

  // Captured frame
  logic [28:0]      id_r;
  logic [DLC_W-1:0] len_r;
  logic [63:0]      data_r;

  // Segment state
  logic                 seg_open_r;
  logic [SEGNUM_W-1:0]  last_segnum_r;
  logic [LEN_W-1:0]     assembled_r;
  logic [STATION_W-1:0] local_station_r;

  // Emission state
  logic [LEN_W-1:0] msg_len_r;
  logic [ROW_W-1:0] chunk_r;
  logic [7:0]       rd_data_r [LANES];

  // Buffer: one bank per byte lane, row = address / LANES
  logic [7:0] msg_mem [LANES][ROWS];

  logic [SEGNUM_W-1:0] segnum;
  logic [LEN_W:0]      append_end;
  logic [LEN_W:0]      msg_total;
  logic [LEN_W-1:0]    base;
  logic                wr_en   [LANES];
  logic [ROW_W-1:0]    wr_row  [LANES];
  logic [7:0]          wr_byte [LANES];

  assign segnum     = id_r[18:12];
  assign append_end = {1'b0, assembled_r} + {{(LEN_W + 1 - DLC_W){1'b0}}, len_r};
  assign msg_total  = cmd.append ? append_end
                                 : {{(LEN_W + 1 - DLC_W){1'b0}}, len_r};
  assign base       = cmd.append ? assembled_r : '0;

  assign status.dst_match  = (id_r[28:21] == local_station_r);
  assign status.segpos     = id_r[20:19];
  assign status.fits       = seg_open_r
                          && ({1'b0, segnum} == ({1'b0, last_segnum_r} + 8'd1))
                          && (append_end <= (LEN_W + 1)'(BUFFER_BYTES));
  assign status.last_chunk = msg_len_r <= {({1'b0, chunk_r} + 4'd1), 3'b000};

  // Byte i of the frame lands in lane (base + i) mod LANES
  always_comb begin
    logic [LANE_W-1:0] idx;
    logic [LEN_W:0]    addr;
    for (int b = 0; b < LANES; b++) begin
      idx        = LANE_W'(b) - base[LANE_W-1:0];
      addr       = {1'b0, base} + {{(LEN_W + 1 - LANE_W){1'b0}}, idx};
      wr_row[b]  = addr[LANE_W +: ROW_W];
      wr_byte[b] = data_r[{idx, 3'b000} +: 8];
      wr_en[b]   = cmd.store
                && ({1'b0, idx} < len_r)
                && (addr < (LEN_W + 1)'(BUFFER_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < LANES; b++) begin
      if (wr_en[b]) begin
        msg_mem[b][wr_row[b]] <= wr_byte[b];
      end
      if (cmd.read) begin
        rd_data_r[b] <= msg_mem[b][chunk_r];
      end
    end
  end

  // Frame capture; length codes above eight count as eight
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r   <= in_data.ext_id;
      data_r <= in_data.frame_data;
      len_r  <= (in_data.dlc > MAX_DLC) ? MAX_DLC : in_data.dlc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_open_r      <= 1'b0;
      last_segnum_r   <= '0;
      assembled_r     <= '0;
      local_station_r <= 8'd1;
    end else begin
      if (cfg_valid) begin
        local_station_r <= cfg_data;
      end
      priority if (cmd.seg_open) begin
        seg_open_r    <= 1'b1;
        last_segnum_r <= segnum;
        assembled_r   <= {{(LEN_W - DLC_W){1'b0}}, len_r};
      end else if (cmd.seg_advance) begin
        last_segnum_r <= segnum;
        assembled_r   <= append_end[LEN_W-1:0];
      end else if (cmd.seg_close) begin
        seg_open_r    <= 1'b0;
        last_segnum_r <= '0;
        assembled_r   <= '0;
      end else begin
        seg_open_r <= seg_open_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (cmd.emit) begin
      chunk_r <= '0;
    end else if (cmd.next_chunk) begin
      chunk_r <= chunk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      msg_len_r <= msg_total[LEN_W-1:0];
    end
  end

  // Result payload; lanes past the message end read zero
  always_comb begin
    out_data.func_code      = id_r[11:8];
    out_data.source_station = id_r[7:0];
    out_data.message_length = msg_len_r;
    out_data.chunk_index    = chunk_r;
    out_data.last_chunk     = status.last_chunk;
    for (int b = 0; b < LANES; b++) begin
      out_data.chunk_bytes[b*8 +: 8] =
        ({1'b0, chunk_r, LANE_W'(b)} < msg_len_r) ? rd_data_r[b] : 8'h00;
    end
  end

endmodule

// ----- design/can_frame_reassembler.sv -----
// Top level of the CAN frame reassembler: controller plus datapath.
//
// Usage:
//   in_*  : one received extended CAN frame per transaction (ext_id, dlc,
//           frame_data). Frames whose destination field differs from the
//           local station are dropped without output.
//   out_* : one transaction per 8-byte chunk of a delivered message, the
//           final chunk flagged by last_chunk. Bytes past message_length
//           read zero.
//   cfg_* : writes local_station; always ready, write only while idle.
// Sequencing:
//   Frames run one at a time. A frame that delivers nothing frees
//   in_ready once it has been processed. A delivering frame presents
//   its first chunk after processing and one banked buffer read; each
//   further chunk takes one banked buffer read and one output state.
// Reset (rst_n low, synchronous): no reassembly open, segment counters
//   zero, local_station = 1. Buffer contents are not cleared.
// Stall: a chunk holds on out_* until out_ready; in_ready stays low
//   until the last chunk of the message has been taken.
`timescale 1ns / 1ps

module can_frame_reassembler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfr_pkg::cfr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfr_pkg::cfr_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import cfr_pkg::*;

  cfr_cmd_t    cmd;
  cfr_status_t status;

  // Register port never stalls
  assign cfg_ready = 1'b1;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cfr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
